### design/ubof_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the UTF-8 break opportunity finder.
// No dependencies; the scanner, the result queue and the top level import this package.
package ubof_pkg;

	// Parameter defaults.
	localparam int MAX_TEXT_BYTES_DEF = 65536;
	localparam int WIDTH_BITS_DEF     = 24;

	// Depth of the result queue; must be a power of two and at least four.
	localparam int QUEUE_DEPTH = 4;

	// Single-byte characters of interest.
	localparam logic [7:0] BYTE_SPACE  = 8'h20;
	localparam logic [7:0] BYTE_TAB    = 8'h09;
	localparam logic [7:0] BYTE_HYPHEN = 8'h2D;

	// Lead byte classes.
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	// Soft hyphen U+00AD.
	localparam logic [7:0] SHY_LEAD  = 8'hC2;
	localparam logic [7:0] SHY_TRAIL = 8'hAD;

	// General punctuation block U+2000 and up: E2 80 xx.
	localparam logic [7:0] PUNCT_LEAD   = 8'hE2;
	localparam logic [7:0] PUNCT_MID    = 8'h80;
	localparam logic [7:0] SPACE_FIRST  = 8'h80;
	localparam logic [7:0] SPACE_LAST   = 8'h8A;
	localparam logic [7:0] EN_DASH_LAST = 8'h93;
	localparam logic [7:0] EM_DASH_LAST = 8'h94;

	// Result slots handed from the scanner to the queue in the same cycle.
	// slot1 is only ever set together with slot0.
	typedef struct packed {
		logic slot0;
		logic slot1;
	} push_t;

endpackage

### design/ubof_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for text bytes in and break results out.
// Depends on nothing; widths are set by the instantiating level.
interface ubof_in_if #(
	parameter int WIDTH_BITS = 24
) ();
	logic                  valid;
	logic                  ready;
	logic [7:0]            text_byte;
	logic [WIDTH_BITS-1:0] width_through;
	logic                  end_of_text;

	modport source(output valid, text_byte, width_through, end_of_text, input ready);
	modport sink(input valid, text_byte, width_through, end_of_text, output ready);
endinterface

interface ubof_out_if #(
	parameter int OFF_W      = 17,
	parameter int WIDTH_BITS = 24
) ();
	logic                  valid;
	logic                  ready;
	logic [OFF_W-1:0]      break_offset;
	logic [WIDTH_BITS-1:0] width_before;
	logic                  visible_hyphen;
	logic                  last_of_run;

	modport source(output valid, break_offset, width_before, visible_hyphen, last_of_run,
		input ready);
	modport sink(input valid, break_offset, width_before, visible_hyphen, last_of_run,
		output ready);
endinterface

### design/ubof_scan.sv
`timescale 1ns / 1ps
// Input register and per-byte character scanner: tracks the current character,
// the held hyphen break and the byte count, and emits up to two results a word.
// Depends on ubof_pkg and the ubof_in_if channel.
module ubof_scan #(
	parameter int MAX_TEXT_BYTES = ubof_pkg::MAX_TEXT_BYTES_DEF,
	parameter int WIDTH_BITS     = ubof_pkg::WIDTH_BITS_DEF,
	localparam int OFF_W         = $clog2(MAX_TEXT_BYTES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ubof_in_if.sink               text,
	input  logic                  room,
	output ubof_pkg::push_t       push,
	output logic [OFF_W-1:0]      s0_offset,
	output logic [WIDTH_BITS-1:0] s0_width,
	output logic                  s0_visible,
	output logic                  s0_last,
	output logic [OFF_W-1:0]      s1_offset,
	output logic [WIDTH_BITS-1:0] s1_width
);
	import ubof_pkg::*;

	// Number of follow-on bytes that a lead byte announces.
	function automatic logic [1:0] lead_extra(input logic [7:0] b);
		logic [1:0] n;
		begin
			n = 2'd0;
			if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				n = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				n = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
				n = 2'd3;
			end
			return n;
		end
	endfunction

	// Input register stage.
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic [WIDTH_BITS-1:0] width_s1;
	logic                  eot_s1;

	// Text state.
	logic [OFF_W-1:0]      byte_count_q;
	logic [1:0]            remaining_q;
	logic [1:0]            extra_q;
	logic [15:0]           char_q;
	logic                  pend_q;
	logic [OFF_W-1:0]      pend_off_q;
	logic [WIDTH_BITS-1:0] pend_w_q;

	logic                  fire;
	logic                  count_ok;
	logic [OFF_W-1:0]      new_count;
	logic [1:0]            extra_cur;
	logic [1:0]            remaining_new;
	logic                  done;
	logic                  brk_space;
	logic                  brk_shy;
	logic                  brk_punct;
	logic                  brk;
	logic                  hyph;

	// The stage moves on whenever the queue can take two results.
	assign fire       = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1  <= text.text_byte;
			width_s1 <= text.width_through;
			eot_s1   <= text.end_of_text;
		end
	end

	// Character assembly and classification.
	always_comb begin
		count_ok  = byte_count_q < OFF_W'(MAX_TEXT_BYTES);
		new_count = byte_count_q + OFF_W'(1);
		if (remaining_q == 2'd0) begin
			extra_cur     = lead_extra(byte_s1);
			remaining_new = extra_cur;
		end else begin
			extra_cur     = extra_q;
			remaining_new = remaining_q - 2'd1;
		end
		done = count_ok && (remaining_new == 2'd0);

		brk_space = done && (extra_cur == 2'd0)
			&& ((byte_s1 == BYTE_SPACE) || (byte_s1 == BYTE_TAB));
		hyph = done && (extra_cur == 2'd0) && (byte_s1 == BYTE_HYPHEN)
			&& (byte_count_q != '0) && !eot_s1;
		brk_shy = done && (extra_cur == 2'd1) && (char_q[7:0] == SHY_LEAD)
			&& (byte_s1 == SHY_TRAIL);
		brk_punct = done && (extra_cur == 2'd2) && (char_q == {PUNCT_LEAD, PUNCT_MID})
			&& (((byte_s1 >= SPACE_FIRST) && (byte_s1 <= SPACE_LAST))
			|| (byte_s1 == EN_DASH_LAST) || (byte_s1 == EM_DASH_LAST));
		brk = brk_space || brk_shy || brk_punct;
	end

	// Result slots: a held hyphen break goes first, then this byte's break.
	always_comb begin
		push.slot0 = fire && (pend_q || brk);
		push.slot1 = fire && pend_q && brk;
		if (pend_q) begin
			s0_offset  = pend_off_q;
			s0_width   = pend_w_q;
			s0_visible = 1'b0;
			s0_last    = !brk;
		end else begin
			s0_offset  = new_count;
			s0_width   = width_s1;
			s0_visible = brk_shy;
			s0_last    = 1'b1;
		end
		s1_offset = new_count;
		s1_width  = width_s1;
	end

	// Control state update; end of text returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			remaining_q  <= 2'd0;
			extra_q      <= 2'd0;
			pend_q       <= 1'b0;
		end else if (fire) begin
			if (eot_s1) begin
				byte_count_q <= '0;
				remaining_q  <= 2'd0;
				extra_q      <= 2'd0;
				pend_q       <= 1'b0;
			end else begin
				pend_q <= hyph;
				if (count_ok) begin
					byte_count_q <= new_count;
					remaining_q  <= remaining_new;
					extra_q      <= extra_cur;
				end
			end
		end
	end

	// Character bytes and the held break payload.
	always_ff @(posedge clk) begin
		if (fire && count_ok) begin
			if (remaining_q == 2'd0) begin
				char_q <= {8'h00, byte_s1};
			end else begin
				char_q <= {char_q[7:0], byte_s1};
			end
		end
		if (fire && hyph) begin
			pend_off_q <= new_count;
			pend_w_q   <= width_s1;
		end
	end

	// A finished text leaves no count and no held break behind.
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eot_s1 |=> (byte_count_q == '0) && !pend_q && (remaining_q == 2'd0))
		else $error("state not cleared after end of text");

	// The byte count never passes the text limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= OFF_W'(MAX_TEXT_BYTES))
		else $error("byte count beyond limit");

	// A held hyphen is released by the very next processed byte.
	a_pend_release: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pend_q |-> push.slot0 && (s0_offset == pend_off_q))
		else $error("held hyphen break not released");

endmodule

### design/ubof_result_fifo.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two results a cycle, delivers one a cycle while ready.
// Depends on ubof_pkg and the ubof_out_if channel.
module ubof_result_fifo #(
	parameter int MAX_TEXT_BYTES = ubof_pkg::MAX_TEXT_BYTES_DEF,
	parameter int WIDTH_BITS     = ubof_pkg::WIDTH_BITS_DEF,
	localparam int OFF_W         = $clog2(MAX_TEXT_BYTES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ubof_pkg::push_t       push,
	input  logic [OFF_W-1:0]      s0_offset,
	input  logic [WIDTH_BITS-1:0] s0_width,
	input  logic                  s0_visible,
	input  logic                  s0_last,
	input  logic [OFF_W-1:0]      s1_offset,
	input  logic [WIDTH_BITS-1:0] s1_width,
	output logic                  room,
	ubof_out_if.source            breaks
);
	import ubof_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [OFF_W-1:0]      off_q   [QUEUE_DEPTH];
	logic [WIDTH_BITS-1:0] width_q [QUEUE_DEPTH];
	logic                  vis_q   [QUEUE_DEPTH];
	logic                  last_q  [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  pop;
	logic [PTR_W-1:0]      wr_next;

	assign pop     = breaks.valid && breaks.ready;
	assign wr_next = wr_ptr_q + PTR_W'(1);
	assign room    = count_q <= CNT_W'(QUEUE_DEPTH - 2);

	// Head of queue drives the channel.
	assign breaks.valid          = count_q != '0;
	assign breaks.break_offset   = off_q[rd_ptr_q];
	assign breaks.width_before   = width_q[rd_ptr_q];
	assign breaks.visible_hyphen = vis_q[rd_ptr_q];
	assign breaks.last_of_run    = last_q[rd_ptr_q];

	// Entry writes; the second slot is always a plain closing break.
	always_ff @(posedge clk) begin
		if (push.slot0) begin
			off_q[wr_ptr_q]   <= s0_offset;
			width_q[wr_ptr_q] <= s0_width;
			vis_q[wr_ptr_q]   <= s0_visible;
			last_q[wr_ptr_q]  <= s0_last;
		end
		if (push.slot1) begin
			off_q[wr_next]   <= s1_offset;
			width_q[wr_next] <= s1_width;
			vis_q[wr_next]   <= 1'b0;
			last_q[wr_next]  <= 1'b1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.slot0) + PTR_W'(push.slot1);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.slot0) + CNT_W'(push.slot1) - CNT_W'(pop);
		end
	end

	// Pushes only arrive while there is space for two.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.slot0 |-> count_q <= CNT_W'(QUEUE_DEPTH - 2))
		else $error("result queue overflow");

	// The second slot never arrives alone.
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.slot1 |-> push.slot0)
		else $error("second result without first");

	// A stalled head word stays put until the receiver takes it.
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		breaks.valid && !breaks.ready |=> breaks.valid && $stable(breaks.break_offset)
		&& $stable(breaks.width_before) && $stable(breaks.last_of_run))
		else $error("head word changed while stalled");

endmodule

### design/utf8_break_opportunity_finder.sv
`timescale 1ns / 1ps
// UTF-8 line-break opportunity finder, top level.
// Instantiates ubof_scan and ubof_result_fifo; uses ubof_pkg and the channel interfaces.
//
// Usage:
//   text   : one UTF-8 byte per word with the measured width through that byte and an
//            end-of-text flag on the final byte of each text.
//   breaks : one word per break opportunity: offset just after the breakable character,
//            width through it, a visible-hyphen flag and a flag on the last word caused
//            by a given input byte.
// An accepted byte is held in the input register; its results are then written into
// the result queue, whose head drives the break channel. One byte is accepted every
// cycle while the queue has room for two words. A byte that releases a held hyphen break
// and also breaks itself gives two words, which leave one per cycle from a four-entry
// result queue; the input register waits whenever the queue holds more than two words,
// so the two-word case and receiver stalls back-pressure the text channel without loss.
// Reset clears the byte count, the character state, the held break and the queue.
// End of text returns the character state to reset after its byte is processed.
module utf8_break_opportunity_finder #(
	parameter int MAX_TEXT_BYTES = ubof_pkg::MAX_TEXT_BYTES_DEF,
	parameter int WIDTH_BITS     = ubof_pkg::WIDTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ubof_in_if.sink    text,
	ubof_out_if.source breaks
);
	import ubof_pkg::*;

	localparam int OFF_W = $clog2(MAX_TEXT_BYTES + 1);

	push_t                 push;
	logic                  room;
	logic [OFF_W-1:0]      s0_offset;
	logic [WIDTH_BITS-1:0] s0_width;
	logic                  s0_visible;
	logic                  s0_last;
	logic [OFF_W-1:0]      s1_offset;
	logic [WIDTH_BITS-1:0] s1_width;

	// Byte scanner and break classification.
	ubof_scan #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES),
		.WIDTH_BITS(WIDTH_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.room(room),
		.push(push),
		.s0_offset(s0_offset),
		.s0_width(s0_width),
		.s0_visible(s0_visible),
		.s0_last(s0_last),
		.s1_offset(s1_offset),
		.s1_width(s1_width)
	);

	// Result queue toward the receiver.
	ubof_result_fifo #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES),
		.WIDTH_BITS(WIDTH_BITS)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.s0_offset(s0_offset),
		.s0_width(s0_width),
		.s0_visible(s0_visible),
		.s0_last(s0_last),
		.s1_offset(s1_offset),
		.s1_width(s1_width),
		.room(room),
		.breaks(breaks)
	);

endmodule

### verif/ubof_checker.sv
`timescale 1ns / 1ps
// Checker for the UTF-8 break opportunity finder: watches the text and break channels,
// predicts the break words of every accepted byte and compares them in order.
// Depends on ubof_pkg for the byte codes.
module ubof_checker #(
	parameter int MAX_TEXT_BYTES = ubof_pkg::MAX_TEXT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic [23:0] width_through,
	input  logic        end_of_text,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [16:0] break_offset,
	input  logic [23:0] width_before,
	input  logic        visible_hyphen,
	input  logic        last_of_run,
	output int          fail_count,
	output int          pending_count,
	output int          words_checked,
	output int          double_bytes
);
	import ubof_pkg::*;

	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic [16:0] offset;
		logic [23:0] width;
		logic        vis;
		logic        last;
	} break_word_t;

	// Scanner state, mirrored from the block's behavior.
	logic [16:0] byte_count;
	logic [16:0] char_start;
	logic [23:0] char_bytes;
	logic [2:0]  bytes_left;
	logic        held_hyphen;
	logic [16:0] held_offset;
	logic [23:0] held_width;

	break_word_t expected_breaks[$];

	// Number of follow-on bytes that a lead byte announces; invalid leads stand alone.
	function automatic logic [2:0] follow_count(input logic [7:0] b);
		if (b[7] == 1'b0)
			return 3'd0;
		if ((b & LEAD2_MASK) == LEAD2_CODE)
			return 3'd1;
		if ((b & LEAD3_MASK) == LEAD3_CODE)
			return 3'd2;
		if ((b & LEAD4_MASK) == LEAD4_CODE)
			return 3'd3;
		return 3'd0;
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] break check: %s", $time, what);
		fail_count++;
	endtask

	// Works out the break words caused by one text byte and queues them.
	task automatic predict_breaks(input logic [7:0] b, input logic [23:0] w, input logic eot);
		break_word_t words[2];
		int          n;
		logic [16:0] char_len;
		logic [7:0]  lo;
		n = 0;
		// A held hyphen break goes out first, whatever this byte is.
		if (held_hyphen) begin
			words[n] = '{held_offset, held_width, 1'b0, 1'b0};
			n++;
			held_hyphen = 1'b0;
		end
		// Bytes past the length limit are dropped.
		if (byte_count < MAX_TEXT_BYTES) begin
			byte_count = byte_count + 17'd1;
			if (bytes_left == 3'd0) begin
				char_start = byte_count - 17'd1;
				char_bytes = {16'h0000, b};
				bytes_left = follow_count(b);
			end else begin
				char_bytes = {char_bytes[15:0], b};
				bytes_left = bytes_left - 3'd1;
			end
			// A completed character may be breakable.
			if (bytes_left == 3'd0) begin
				char_len = byte_count - char_start;
				lo = char_bytes[7:0];
				if (char_len == 17'd1) begin
					if (b == BYTE_SPACE || b == BYTE_TAB) begin
						words[n] = '{byte_count, w, 1'b0, 1'b0};
						n++;
					end else if (b == BYTE_HYPHEN && char_start != 17'd0 && !eot) begin
						held_hyphen = 1'b1;
						held_offset = byte_count;
						held_width  = w;
					end
				end else if (char_len == 17'd2) begin
					if (char_bytes == {8'h00, SHY_LEAD, SHY_TRAIL}) begin
						words[n] = '{byte_count, w, 1'b1, 1'b0};
						n++;
					end
				end else if (char_len == 17'd3) begin
					if (char_bytes[23:8] == {PUNCT_LEAD, PUNCT_MID} &&
						((lo >= SPACE_FIRST && lo <= SPACE_LAST) ||
						lo == EN_DASH_LAST || lo == EM_DASH_LAST)) begin
						words[n] = '{byte_count, w, 1'b0, 1'b0};
						n++;
					end
				end
			end
		end
		// End of text puts the scanner back to its reset state.
		if (eot) begin
			byte_count  = '0;
			char_start  = '0;
			char_bytes  = '0;
			bytes_left  = '0;
			held_hyphen = 1'b0;
			held_offset = '0;
			held_width  = '0;
		end
		if (n > 0)
			words[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_breaks = {expected_breaks, words[i]};
		if (n == 2)
			double_bytes++;
	endtask

	// Compare accepted break words first, then predict from the accepted text word.
	always @(posedge clk or negedge arst_n) begin
		break_word_t want;
		if (!arst_n) begin
			byte_count  = '0;
			char_start  = '0;
			char_bytes  = '0;
			bytes_left  = '0;
			held_hyphen = 1'b0;
			held_offset = '0;
			held_width  = '0;
			expected_breaks.delete();
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_breaks.size() == 0) begin
					report_mismatch($sformatf("unexpected word at offset %0d", break_offset));
				end else begin
					want = expected_breaks.pop_front();
					if (break_offset !== want.offset)
						report_mismatch($sformatf("break_offset got %0d, want %0d",
							break_offset, want.offset));
					if (width_before !== want.width)
						report_mismatch($sformatf("width_before got %0h, want %0h at offset %0d",
							width_before, want.width, want.offset));
					if (visible_hyphen !== want.vis)
						report_mismatch($sformatf("visible_hyphen got %b, want %b at offset %0d",
							visible_hyphen, want.vis, want.offset));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run got %b, want %b at offset %0d",
							last_of_run, want.last, want.offset));
					words_checked++;
				end
			end
			if (in_valid && in_ready)
				predict_breaks(text_byte, width_through, end_of_text);
			pending_count = expected_breaks.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the UTF-8 break opportunity finder: clock, reset, text stimulus,
// receiver stalls, a stall watchdog and the verdict.
// Depends on ubof_pkg, the channel interfaces, the block and ubof_checker.
module tb;
	import ubof_pkg::*;

	localparam int OFF_W          = 17;
	localparam int RANDOM_BYTES   = 480;
	localparam int NOGAP_BYTES    = 120;
	localparam int IDLE_PCT       = 30;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	// Extra characters used by the stimulus.
	localparam logic [7:0] CHAR_A          = 8'h61;
	localparam logic [7:0] CONT_BASE       = 8'h80;
	localparam logic [7:0] NBSP_TRAIL      = 8'hA0;
	localparam logic [7:0] NB_HYPHEN_LAST  = 8'h91;
	localparam logic [7:0] FIGURE_DASH     = 8'h92;
	localparam logic [7:0] ZWSP_LAST       = 8'h8B;
	localparam logic [7:0] JOINER_MID      = 8'h81;
	localparam logic [7:0] JOINER_LAST     = 8'hA0;

	typedef enum {WIDTH_FROM_ZERO, WIDTH_NEAR_TOP, WIDTH_RANDOM} width_mode_t;

	logic clk;
	logic arst_n;

	ubof_in_if #(.WIDTH_BITS(WIDTH_BITS_DEF)) text_ch ();
	ubof_out_if #(.OFF_W(OFF_W), .WIDTH_BITS(WIDTH_BITS_DEF)) brk_ch ();

	int unsigned idle_pct = 0;
	int          fail_count;
	int          pending_count;
	int          words_checked;
	int          double_bytes;
	int          bytes_sent = 0;
	int          texts_sent = 0;
	int          quiet_cycles = 0;
	logic [23:0] run_width;
	logic [7:0]  text_buf[$];

	utf8_break_opportunity_finder u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.breaks(brk_ch)
	);

	ubof_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (text_ch.valid),
		.in_ready      (text_ch.ready),
		.text_byte     (text_ch.text_byte),
		.width_through (text_ch.width_through),
		.end_of_text   (text_ch.end_of_text),
		.out_valid     (brk_ch.valid),
		.out_ready     (brk_ch.ready),
		.break_offset  (brk_ch.break_offset),
		.width_before  (brk_ch.width_before),
		.visible_hyphen(brk_ch.visible_hyphen),
		.last_of_run   (brk_ch.last_of_run),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.words_checked (words_checked),
		.double_bytes  (double_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver stalls at the same rate as the sender's gaps.
	always @(negedge clk) begin
		brk_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (brk_ch.valid && brk_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Appends one byte to the text being built.
	function automatic void add_byte(input logic [7:0] b);
		text_buf = {text_buf, b};
	endfunction

	// Offers one text word, with random gaps first, and returns at the falling edge after
	// it has been taken.
	task automatic send_byte(input logic [7:0] b, input logic [23:0] w, input logic eot);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid         <= 1'b1;
		text_ch.text_byte     <= b;
		text_ch.width_through <= w;
		text_ch.end_of_text   <= eot;
		do
			@(posedge clk);
		while (text_ch.ready !== 1'b1);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Sends the buffered text with widths that climb, or with random widths.
	task automatic send_text(input width_mode_t mode);
		logic [23:0] w;
		int          i;
		case (mode)
			WIDTH_FROM_ZERO: run_width = '0;
			WIDTH_NEAR_TOP:  run_width = 24'hFFFFFF - 24'($urandom_range(0, 3000));
			default:         run_width = 24'($urandom);
		endcase
		for (i = 0; i < text_buf.size(); i++) begin
			if (mode == WIDTH_RANDOM) begin
				w = 24'($urandom);
			end else begin
				w = run_width;
				run_width = run_width + 24'($urandom_range(0, 700));
			end
			send_byte(text_buf[i], w, i == text_buf.size() - 1);
		end
		texts_sent++;
	endtask

	// Mostly well-formed text with random content, some noise and cut-off characters.
	task automatic build_random_text();
		int         n_chars;
		int         c;
		int         kind;
		logic [7:0] r;
		text_buf.delete();
		n_chars = $urandom_range(1, 12);
		for (c = 0; c < n_chars; c++) begin
			kind = $urandom_range(0, 15);
			r = 8'($urandom);
			case (kind)
				0, 1, 2: add_byte(CHAR_A + 8'($urandom_range(0, 25)));
				3: add_byte(BYTE_SPACE);
				4: add_byte(BYTE_TAB);
				5, 6: add_byte(BYTE_HYPHEN);
				7: begin
					add_byte(SHY_LEAD);
					add_byte(SHY_TRAIL);
				end
				8: begin
					add_byte(PUNCT_LEAD);
					add_byte(PUNCT_MID);
					add_byte(SPACE_FIRST + 8'($urandom_range(0, 10)));
				end
				9: begin
					add_byte(PUNCT_LEAD);
					add_byte(PUNCT_MID);
					add_byte(r[0] ? EN_DASH_LAST : EM_DASH_LAST);
				end
				10: begin
					// Characters that look like breaks but must not give one.
					case ($urandom_range(0, 4))
						0: begin
							add_byte(SHY_LEAD);
							add_byte(NBSP_TRAIL);
						end
						1: begin
							add_byte(PUNCT_LEAD);
							add_byte(PUNCT_MID);
							add_byte(NB_HYPHEN_LAST);
						end
						2: begin
							add_byte(PUNCT_LEAD);
							add_byte(JOINER_MID);
							add_byte(JOINER_LAST);
						end
						3: begin
							add_byte(PUNCT_LEAD);
							add_byte(PUNCT_MID);
							add_byte(ZWSP_LAST);
						end
						default: begin
							add_byte(PUNCT_LEAD);
							add_byte(PUNCT_MID);
							add_byte(FIGURE_DASH);
						end
					endcase
				end
				11: begin
					add_byte(LEAD2_CODE | {3'b000, r[4:0]});
					add_byte(8'($urandom));
				end
				12: begin
					// Any three-byte character, often in the punctuation block.
					add_byte(r[7] ? PUNCT_LEAD : (LEAD3_CODE | {4'h0, r[3:0]}));
					add_byte(r[6] ? PUNCT_MID : 8'($urandom));
					add_byte(8'($urandom));
				end
				13: begin
					add_byte(LEAD4_CODE | {5'b00000, r[2:0]});
					add_byte(CONT_BASE | 8'($urandom_range(0, 63)));
					add_byte(CONT_BASE | 8'($urandom_range(0, 63)));
					add_byte(CONT_BASE | 8'($urandom_range(0, 63)));
				end
				14: add_byte(r);
				default: add_byte({1'b0, r[6:0]});
			endcase
		end
		// Sometimes the text stops in the middle of a character.
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 2))
				0: add_byte(SHY_LEAD);
				1: begin
					add_byte(PUNCT_LEAD);
					add_byte(PUNCT_MID);
				end
				default: begin
					add_byte(LEAD4_CODE);
					add_byte(CONT_BASE | 8'($urandom_range(0, 63)));
					add_byte(CONT_BASE | 8'($urandom_range(0, 63)));
				end
			endcase
		end
	endtask

	initial begin
		int random_start;
		arst_n                = 1'b0;
		text_ch.valid         = 1'b0;
		text_ch.text_byte     = '0;
		text_ch.width_through = '0;
		text_ch.end_of_text   = 1'b0;
		brk_ch.ready          = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: hyphen first and last, a held hyphen released by a space.
		idle_pct = IDLE_PCT;
		text_buf = '{BYTE_HYPHEN, CHAR_A, BYTE_HYPHEN, BYTE_SPACE, BYTE_HYPHEN};
		send_text(WIDTH_FROM_ZERO);

		// Directed: tab, both ends of the space range, soft hyphen, en and em dash, a non-breaking hyphen, a cut-off tail.
		text_buf = '{BYTE_TAB,
			PUNCT_LEAD, PUNCT_MID, SPACE_FIRST,
			PUNCT_LEAD, PUNCT_MID, SPACE_LAST,
			SHY_LEAD, SHY_TRAIL,
			PUNCT_LEAD, PUNCT_MID, EN_DASH_LAST,
			PUNCT_LEAD, PUNCT_MID, EM_DASH_LAST,
			PUNCT_LEAD, PUNCT_MID, NB_HYPHEN_LAST,
			PUNCT_LEAD};
		send_text(WIDTH_NEAR_TOP);

		// Directed: width extremes on single-character texts.
		send_byte(BYTE_SPACE, 24'h000000, 1'b1);
		send_byte(BYTE_TAB, 24'hFFFFFF, 1'b1);
		texts_sent += 2;

		// Random texts sent without any gaps or stalls.
		idle_pct = 0;
		random_start = bytes_sent;
		while (bytes_sent - random_start < NOGAP_BYTES) begin
			build_random_text();
			send_text(WIDTH_RANDOM);
		end

		// Random texts with gaps and stalls.
		idle_pct = IDLE_PCT;
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			build_random_text();
			case ($urandom_range(0, 3))
				0: send_text(WIDTH_FROM_ZERO);
				1: send_text(WIDTH_NEAR_TOP);
				default: send_text(WIDTH_RANDOM);
			endcase
		end
		text_ch.valid <= 1'b0;

		// Let every expected word arrive, then watch for strays.
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d text bytes in %0d texts, with and without sender gaps and stalls.",
			bytes_sent, texts_sent);
		$display("Checked %0d break words; %0d bytes gave two words each.",
			words_checked, double_bytes);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
